FILE: hdl/temporal_stream_prefetcher_defines.svh
// ----------------------------------------------------------------------------
// Temporal stream prefetcher assertion macros
// Shared property forms, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef TEMPORAL_STREAM_PREFETCHER_DEFINES_SVH
`define TEMPORAL_STREAM_PREFETCHER_DEFINES_SVH

// same-cycle implication
`define TSP_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TSP_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/tsp_pkg.sv
// ----------------------------------------------------------------------------
// Temporal stream prefetcher package
// Widths, defaults, controller states and index port bundles.
// ----------------------------------------------------------------------------
package tsp_pkg;

	localparam int ADDR_W     = 64;
	localparam int LINE_SHIFT = 6;
	localparam int LINE_W     = ADDR_W - LINE_SHIFT;
	localparam int LOOKAHEAD  = 32;
	localparam int DEG_W      = 6;
	localparam int IN_USER_W  = 2;
	localparam int OUT_USER_W = 1;

	localparam logic [DEG_W-1:0] DEGREE_RESET = 6'd4;

	// depths must be powers of two
	localparam int HISTORY_DEPTH_DEF = 4096;
	localparam int INDEX_DEPTH_DEF   = 1024;
	localparam int MAX_DEGREE_DEF    = 32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_IDX,
		ST_RING,
		ST_EMIT,
		ST_UPDATE
	} tsp_state_t;

	typedef struct packed {
		logic rd;
		logic wr;
	} tsp_idx_req_t;

	typedef struct packed {
		logic busy;
		logic hit;
	} tsp_idx_sts_t;

endpackage

FILE: hdl/tsp_index.sv
// ----------------------------------------------------------------------------
// Temporal stream prefetcher index table
// Direct-mapped tagged table from line to newest ring slot, with a clearing
// sweep after reset and a tag compare on the registered read data.
// ----------------------------------------------------------------------------
module tsp_index #(
	parameter int INDEX_DEPTH = tsp_pkg::INDEX_DEPTH_DEF,
	parameter int SLOT_W      = 12
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  tsp_pkg::tsp_idx_req_t                        req,
	input  logic [$clog2(INDEX_DEPTH)-1:0]               rd_set,
	input  logic [tsp_pkg::LINE_W-$clog2(INDEX_DEPTH)-1:0] lookup_tag,
	input  logic [$clog2(INDEX_DEPTH)-1:0]               wr_set,
	input  logic [tsp_pkg::LINE_W-$clog2(INDEX_DEPTH)-1:0] wr_tag,
	input  logic [SLOT_W-1:0]                            wr_slot,
	output tsp_pkg::tsp_idx_sts_t                        sts,
	output logic [SLOT_W-1:0]                            slot
);
	import tsp_pkg::*;

	localparam int IDX_W = $clog2(INDEX_DEPTH);
	localparam int TAG_W = LINE_W - IDX_W;
	localparam int ENT_W = 1 + TAG_W + SLOT_W;

	logic [ENT_W-1:0] mem [INDEX_DEPTH];
	logic [ENT_W-1:0] rdata_q;
	logic             busy_q;
	logic [IDX_W-1:0] clr_addr_q;

	logic             we;
	logic [IDX_W-1:0] waddr;
	logic [ENT_W-1:0] wdata;

	// clearing sweep owns the write port until every entry is invalid
	always_comb begin
		we    = busy_q | req.wr;
		waddr = busy_q ? clr_addr_q : wr_set;
		wdata = busy_q ? '0 : {1'b1, wr_tag, wr_slot};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b1;
			clr_addr_q <= '0;
		end else if (busy_q) begin
			clr_addr_q <= clr_addr_q + IDX_W'(1);
			if (clr_addr_q == IDX_W'(INDEX_DEPTH - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (req.rd) begin
			rdata_q <= mem[rd_set];
		end
	end

	always_comb begin
		sts.busy = busy_q;
		sts.hit  = rdata_q[ENT_W-1] && (rdata_q[ENT_W-2:SLOT_W] == lookup_tag);
		slot     = rdata_q[SLOT_W-1:0];
	end

endmodule

FILE: hdl/temporal_stream_prefetcher.sv
// ----------------------------------------------------------------------------
// Temporal stream prefetcher
// Load misses look up their line in an index that points into a global
// history ring; on a hit the lines that followed are issued as prefetches.
// ----------------------------------------------------------------------------
// channel   dir  tdata                 tuser               tlast
// s_axis    in   access_address[63:0]  [0] is_load [1] was_hit  -
// m_axis    out  prefetch_address      [0] fill_this_level last_of_run
// cfg       in   prefetch_degree_wr_data, taken on prefetch_degree_wr_en
//
// Filtered items (store, hit, repeated line) are accepted without leaving idle.
// A trigger miss does index read, ring read and compare, one address a cycle
// while m_axis is free, then ring/index update; an index miss skips to update.
// After reset every index entry is cleared; input waits until the sweep ends.
// A stalled m_axis holds the ring readout; input is taken only when idle.
// ----------------------------------------------------------------------------
`include "temporal_stream_prefetcher_defines.svh"

module temporal_stream_prefetcher #(
	parameter int HISTORY_DEPTH = tsp_pkg::HISTORY_DEPTH_DEF,
	parameter int INDEX_DEPTH   = tsp_pkg::INDEX_DEPTH_DEF,
	parameter int MAX_DEGREE    = tsp_pkg::MAX_DEGREE_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [tsp_pkg::ADDR_W-1:0]       s_axis_tdata,  // access_address
	input  logic [tsp_pkg::IN_USER_W-1:0]    s_axis_tuser,  // is_load, was_hit
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [tsp_pkg::ADDR_W-1:0]       m_axis_tdata,  // prefetch_address
	output logic [tsp_pkg::OUT_USER_W-1:0]   m_axis_tuser,  // fill_this_level
	output logic                             m_axis_tlast,
	input  logic                             prefetch_degree_wr_en,
	input  logic [tsp_pkg::DEG_W-1:0]        prefetch_degree_wr_data
);
	import tsp_pkg::*;

	localparam int HIST_W  = $clog2(HISTORY_DEPTH);
	localparam int IDX_W   = $clog2(INDEX_DEPTH);
	localparam int DEG_CAP = (MAX_DEGREE < LOOKAHEAD) ? MAX_DEGREE : LOOKAHEAD;

	tsp_state_t state_q, state_d;

	logic [DEG_W-1:0]  degree_q;
	logic [LINE_W-1:0] prev_line_q;
	logic              prev_valid_q;
	logic [LINE_W-1:0] line_q;
	logic [HIST_W-1:0] head_q;
	logic [HIST_W-1:0] ptr_q;
	logic [DEG_W-1:0]  cnt_q;
	logic [DEG_W-1:0]  n_q;

	logic [LINE_W-1:0] ring_mem [HISTORY_DEPTH];
	logic [LINE_W-1:0] ring_rdata_q;

	logic              out_valid_q;
	logic [LINE_W-1:0] out_line_q;
	logic              out_last_q;

	logic              in_fire;
	logic [LINE_W-1:0] in_line;
	logic              trigger;
	logic              out_free;
	logic [HIST_W-1:0] newer;
	logic [DEG_W-1:0]  deg_lim;
	logic [DEG_W-1:0]  n_calc;
	logic              ring_rd;
	logic [HIST_W-1:0] ring_raddr;
	logic              ring_wr;
	logic              out_load;
	logic              out_last_d;
	logic              run_start;
	logic              cnt_inc;

	tsp_idx_req_t      idx_req;
	tsp_idx_sts_t      idx_sts;
	logic [HIST_W-1:0] idx_slot;

	tsp_index #(
		.INDEX_DEPTH (INDEX_DEPTH),
		.SLOT_W      (HIST_W)
	) u_index (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (idx_req),
		.rd_set     (in_line[IDX_W-1:0]),
		.lookup_tag (line_q[LINE_W-1:IDX_W]),
		.wr_set     (line_q[IDX_W-1:0]),
		.wr_tag     (line_q[LINE_W-1:IDX_W]),
		.wr_slot    (head_q),
		.sts        (idx_sts),
		.slot       (idx_slot)
	);

	assign in_fire  = s_axis_tvalid & s_axis_tready;
	assign in_line  = s_axis_tdata[ADDR_W-1:LINE_SHIFT];
	assign trigger  = in_fire && s_axis_tuser[0] && !s_axis_tuser[1]
		&& !(prev_valid_q && (in_line == prev_line_q));
	assign out_free = !out_valid_q || m_axis_tready;

	// ring entries written after slot ptr_q
	assign newer   = head_q - HIST_W'(1) - ptr_q;
	assign deg_lim = (degree_q > DEG_W'(DEG_CAP)) ? DEG_W'(DEG_CAP) : degree_q;
	assign n_calc  = (HIST_W'(deg_lim) > newer) ? DEG_W'(newer) : deg_lim;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		idx_req.rd    = 1'b0;
		idx_req.wr    = 1'b0;
		ring_rd       = 1'b0;
		ring_raddr    = ptr_q + HIST_W'(1);
		ring_wr       = 1'b0;
		out_load      = 1'b0;
		out_last_d    = (cnt_q == n_q);
		run_start     = 1'b0;
		cnt_inc       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = !idx_sts.busy;
				if (trigger) begin
					idx_req.rd = 1'b1;
					state_d    = ST_IDX;
				end
			end
			ST_IDX: begin
				if (idx_sts.hit) begin
					ring_rd    = 1'b1;
					ring_raddr = idx_slot;
					state_d    = ST_RING;
				end else begin
					state_d = ST_UPDATE;
				end
			end
			ST_RING: begin
				// stale entry when the slot was overwritten by another line
				if ((ring_rdata_q == line_q) && (n_calc != '0)) begin
					ring_rd   = 1'b1;
					run_start = 1'b1;
					state_d   = ST_EMIT;
				end else begin
					state_d = ST_UPDATE;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					if (out_last_d) begin
						state_d = ST_UPDATE;
					end else begin
						ring_rd = 1'b1;
						cnt_inc = 1'b1;
					end
				end
			end
			ST_UPDATE: begin
				ring_wr    = 1'b1;
				idx_req.wr = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q     <= DEGREE_RESET;
			prev_line_q  <= '0;
			prev_valid_q <= 1'b0;
			head_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (prefetch_degree_wr_en) begin
				degree_q <= prefetch_degree_wr_data;
			end
			if (trigger) begin
				prev_line_q  <= in_line;
				prev_valid_q <= 1'b1;
			end
			if (ring_wr) begin
				head_q <= head_q + HIST_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (trigger) begin
			line_q <= in_line;
		end
		if (ring_rd) begin
			ptr_q <= ring_raddr;
		end
		if (run_start) begin
			n_q   <= n_calc;
			cnt_q <= DEG_W'(1);
		end else if (cnt_inc) begin
			cnt_q <= cnt_q + DEG_W'(1);
		end
		if (out_load) begin
			out_line_q <= ring_rdata_q;
			out_last_q <= out_last_d;
		end
	end

	// history ring
	always_ff @(posedge clk) begin
		if (ring_wr) begin
			ring_mem[head_q] <= line_q;
		end
		if (ring_rd) begin
			ring_rdata_q <= ring_mem[ring_raddr];
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_line_q, LINE_SHIFT'(0)};
	assign m_axis_tuser  = OUT_USER_W'(1);
	assign m_axis_tlast  = out_last_q;

	`TSP_ASSERT_IMP(a_clear_blocks_input, idx_sts.busy, !s_axis_tready,
		"request accepted during index clearing sweep")
	`TSP_ASSERT_IMP(a_emit_count_bound, state_q == ST_EMIT,
		(cnt_q != '0) && (cnt_q <= n_q) && (n_q <= DEG_W'(DEG_CAP)),
		"prefetch count out of range")
	`TSP_ASSERT_NXT(a_last_ends_run, out_load && out_last_d,
		(state_q == ST_UPDATE) && m_axis_tlast,
		"last prefetch did not close the run")
	`TSP_ASSERT_NXT(a_head_advances, state_q == ST_UPDATE,
		(head_q == HIST_W'($past(head_q) + HIST_W'(1))) && (state_q == ST_IDLE),
		"ring head did not advance on update")

endmodule
